// ===== src/linsfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN slave frame receiver package
// Shared widths, event and register codes, configuration and result types.
// ----------------------------------------------------------------------------
package linsfr_pkg;

    localparam int ID_W               = 6;
    localparam int BYTE_W             = 8;
    localparam int MAX_RESPONSE_BYTES = 8;
    localparam int PAYLOAD_W          = MAX_RESPONSE_BYTES * BYTE_W;
    localparam int DEF_RESPONSE_BYTES = 8;
    localparam int APB_ADDR_W         = 5;
    localparam int APB_DATA_W         = 32;
    localparam int FUNC_W             = 2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

    // Register reset values.
    localparam logic [ID_W-1:0] RST_RELAY_ID  = 6'd0;
    localparam logic [ID_W-1:0] RST_ENGINE_ID = 6'd1;
    localparam logic [ID_W-1:0] RST_LEFT_BIT  = 6'd0;
    localparam logic [ID_W-1:0] RST_RIGHT_BIT = 6'd1;
    localparam logic [ID_W-1:0] RST_HEAD_BIT  = 6'd2;
    localparam logic [ID_W-1:0] RST_LOW_BIT   = 6'd3;
    localparam logic [ID_W-1:0] RST_HIGH_BIT  = 6'd4;

    // UART event kinds.
    typedef enum logic [FUNC_W-1:0] {
        FN_BYTE  = 2'd0,
        FN_BREAK = 2'd1,
        FN_ERROR = 2'd2
    } t_func;

    // Register index, taken from paddr word address.
    typedef enum logic [2:0] {
        REG_RELAY_ID  = 3'd0,
        REG_ENGINE_ID = 3'd1,
        REG_LEFT_BIT  = 3'd2,
        REG_RIGHT_BIT = 3'd3,
        REG_HEAD_BIT  = 3'd4,
        REG_LOW_BIT   = 3'd5,
        REG_HIGH_BIT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [ID_W-1:0] relay_id;
        logic [ID_W-1:0] engine_id;
        logic [ID_W-1:0] left_bit;
        logic [ID_W-1:0] right_bit;
        logic [ID_W-1:0] head_bit;
        logic [ID_W-1:0] low_bit;
        logic [ID_W-1:0] high_bit;
    } t_cfg;

    typedef struct packed {
        logic                 link_up;
        logic                 high_beam;
        logic                 low_beam;
        logic                 right_turn;
        logic                 left_turn;
        logic                 is_relay_frame;
        logic [PAYLOAD_W-1:0] payload;
        logic [ID_W-1:0]      frame_id;
    } t_result;

endpackage

// ===== src/linsfr_rx_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame receive core
// Frame phase tracking, response byte buffer, lamp flags and link flag.
// ----------------------------------------------------------------------------
module linsfr_rx_core #(
    parameter int RESPONSE_BYTES = linsfr_pkg::DEF_RESPONSE_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  linsfr_pkg::t_func                   i_func,
    input  logic [linsfr_pkg::BYTE_W-1:0]       i_byte,
    input  linsfr_pkg::t_cfg                    i_cfg,
    output logic                                o_emit,
    output linsfr_pkg::t_result                 o_result
);
    import linsfr_pkg::*;

    localparam int CNT_W = (RESPONSE_BYTES > 1) ? $clog2(RESPONSE_BYTES) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(RESPONSE_BYTES - 1);

    typedef enum logic [3:0] {
        PH_WAIT_BREAK  = 4'b0001,
        PH_WAIT_SYNC   = 4'b0010,
        PH_WAIT_HEADER = 4'b0100,
        PH_WAIT_RESP   = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [ID_W-1:0]    r_id, n_id;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [3:0]         r_lamps, n_lamps;
    logic               r_link, n_link;
    logic [BYTE_W-1:0]  r_buf [RESPONSE_BYTES];

    logic [PAYLOAD_W-1:0] w_payload;
    logic                 w_resp_byte;
    logic                 w_relay;
    logic [3:0]           w_new_lamps;

    assign w_resp_byte = (i_func == FN_BYTE) && (r_phase == PH_WAIT_RESP);
    assign o_emit      = w_resp_byte && (r_cnt == LAST_CNT);
    assign w_relay     = (r_id == i_cfg.relay_id);

    // The byte arriving now completes the frame, so it is merged in directly.
    always_comb begin
        w_payload = '0;
        for (int i = 0; i < RESPONSE_BYTES; i++) begin
            w_payload[BYTE_W*i +: BYTE_W] = (r_cnt == CNT_W'(i)) ? i_byte : r_buf[i];
        end
    end

    always_comb begin
        w_new_lamps[0] = w_payload[i_cfg.left_bit];
        w_new_lamps[1] = w_payload[i_cfg.right_bit];
        w_new_lamps[2] = w_payload[i_cfg.head_bit] | w_payload[i_cfg.low_bit];
        w_new_lamps[3] = w_payload[i_cfg.high_bit];
    end

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_cnt   = r_cnt;
        n_lamps = r_lamps;
        n_link  = r_link;
        if (i_step) begin
            case (i_func)
                FN_BREAK: begin
                    n_phase = PH_WAIT_SYNC;
                    n_id    = '0;
                    n_cnt   = '0;
                end
                FN_ERROR: begin
                    n_phase = PH_WAIT_BREAK;
                    n_id    = '0;
                    n_cnt   = '0;
                end
                FN_BYTE: begin
                    case (r_phase)
                        PH_WAIT_SYNC: begin
                            n_phase = (i_byte == SYNC_BYTE) ? PH_WAIT_HEADER : PH_WAIT_BREAK;
                        end
                        PH_WAIT_HEADER: begin
                            n_id  = i_byte[ID_W-1:0];
                            n_cnt = '0;
                            if ((i_byte[ID_W-1:0] == i_cfg.relay_id) ||
                                (i_byte[ID_W-1:0] == i_cfg.engine_id)) begin
                                n_phase = PH_WAIT_RESP;
                            end else begin
                                n_phase = PH_WAIT_BREAK;
                            end
                        end
                        PH_WAIT_RESP: begin
                            if (r_cnt == LAST_CNT) begin
                                n_phase = PH_WAIT_BREAK;
                                n_cnt   = '0;
                                if (w_relay) begin
                                    n_lamps = w_new_lamps;
                                    n_link  = 1'b1;
                                end
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_BREAK;
            r_id    <= '0;
            r_cnt   <= '0;
            r_lamps <= '0;
            r_link  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_cnt   <= n_cnt;
            r_lamps <= n_lamps;
            r_link  <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_resp_byte) begin
            r_buf[r_cnt] <= i_byte;
        end
    end

    // The result carries the lamp flags as they stand after this frame.
    always_comb begin
        o_result.frame_id       = r_id;
        o_result.payload        = w_payload;
        o_result.is_relay_frame = w_relay;
        o_result.left_turn      = n_lamps[0];
        o_result.right_turn     = n_lamps[1];
        o_result.low_beam       = n_lamps[2];
        o_result.high_beam      = n_lamps[3];
        o_result.link_up        = n_link;
    end

    a_link_sticky: assert property (@(posedge i_clk)
        $fell(r_link) |-> !$past(i_rst_n))
        else $error("link flag dropped without reset");

    a_lamps_on_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_lamps) |-> ($past(i_step && o_emit && w_relay) || !$past(i_rst_n)))
        else $error("lamp flags changed outside a relay frame completion");

    a_break_arms_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_func == FN_BREAK)) |=> (r_phase == PH_WAIT_SYNC))
        else $error("break did not arm sync wait");

    a_cnt_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_phase == PH_WAIT_RESP))
        else $error("byte counter running outside response phase");

endmodule

// ===== src/lin_slave_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN slave frame receiver
// Receive side of a LIN slave: break, sync and identifier handling, response
// collection for two configured frames, and relay lamp flag decoding.
// ----------------------------------------------------------------------------
// Each input beat is one UART event (received byte, break or line error) and
// the block takes one beat per clock cycle unless stalled. A beat lands in an
// input register and is processed by the receive core as it leaves that
// register, the frame state being updated in that single step; a completed
// frame is written to an output register, so a last response byte passes the
// input register and then the output register before its result appears on
// the master side. The only stall is when the input register holds a
// frame-completing byte while the output register still holds an untaken
// result; beats that produce no result always pass. Events of kind three are
// consumed and ignored. The configuration registers are word addressed over
// APB and should only be written while no frame is being emitted.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver #(
    parameter int RESPONSE_BYTES = linsfr_pkg::DEF_RESPONSE_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: one UART event per beat.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]                          s_axis_tuser,   // [1:0] func
    // Master side: one completed frame per beat.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] frame_id, [69:6] payload, [70] left_turn, [71] right_turn,
    // [72] low_beam, [73] high_beam, [74] link_up, [79:75] zero
    output logic [79:0]                         m_axis_tdata,
    output logic [0:0]                          m_axis_tuser,   // [0] is_relay_frame
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [linsfr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [linsfr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [linsfr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);
    import linsfr_pkg::*;

    // Configuration registers.
    t_cfg     r_cfg, n_cfg;
    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RELAY_ID:  n_cfg.relay_id  = pwdata[ID_W-1:0];
                REG_ENGINE_ID: n_cfg.engine_id = pwdata[ID_W-1:0];
                REG_LEFT_BIT:  n_cfg.left_bit  = pwdata[ID_W-1:0];
                REG_RIGHT_BIT: n_cfg.right_bit = pwdata[ID_W-1:0];
                REG_HEAD_BIT:  n_cfg.head_bit  = pwdata[ID_W-1:0];
                REG_LOW_BIT:   n_cfg.low_bit   = pwdata[ID_W-1:0];
                REG_HIGH_BIT:  n_cfg.high_bit  = pwdata[ID_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RELAY_ID:  prdata = APB_DATA_W'(r_cfg.relay_id);
            REG_ENGINE_ID: prdata = APB_DATA_W'(r_cfg.engine_id);
            REG_LEFT_BIT:  prdata = APB_DATA_W'(r_cfg.left_bit);
            REG_RIGHT_BIT: prdata = APB_DATA_W'(r_cfg.right_bit);
            REG_HEAD_BIT:  prdata = APB_DATA_W'(r_cfg.head_bit);
            REG_LOW_BIT:   prdata = APB_DATA_W'(r_cfg.low_bit);
            REG_HIGH_BIT:  prdata = APB_DATA_W'(r_cfg.high_bit);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relay_id  <= RST_RELAY_ID;
            r_cfg.engine_id <= RST_ENGINE_ID;
            r_cfg.left_bit  <= RST_LEFT_BIT;
            r_cfg.right_bit <= RST_RIGHT_BIT;
            r_cfg.head_bit  <= RST_HEAD_BIT;
            r_cfg.low_bit   <= RST_LOW_BIT;
            r_cfg.high_bit  <= RST_HIGH_BIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input register stage.
    logic              r_in_valid, n_in_valid;
    t_func             r_in_func;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_in_take;
    logic              w_step;
    logic              w_emit;
    t_result           w_result;

    // Output register stage.
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    // The held beat advances unless it completes a frame and the output
    // register is occupied by a result that is not leaving this cycle.
    assign w_step        = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step && w_emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_func <= t_func'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    linsfr_rx_core #(
        .RESPONSE_BYTES (RESPONSE_BYTES)
    ) u_rx_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_func   (r_in_func),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.link_up, r_out.high_beam, r_out.low_beam,
                            r_out.right_turn, r_out.left_turn, r_out.payload,
                            r_out.frame_id};
    assign m_axis_tuser  = r_out.is_relay_frame;

endmodule
